// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and command codes of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned LAST_ROW   = (ROWS - 1) * COLUMNS;

  // Field widths.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = 11;
  localparam int unsigned WORD_W = ATTR_W + CHAR_W;
  localparam int unsigned COL_W  = $clog2(COLUMNS);

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ATTR_W-1:0] attr_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  localparam char_t NEWLINE_CODE = 8'h0A;
  localparam char_t SPACE_CODE   = 8'h20;
  localparam attr_t ATTR_RESET   = 8'h0F;

  // Cursor update request from the sequencer.
  typedef struct packed {
    logic step;     // a character or newline beat was taken
    logic newline;  // the character is a newline
    logic home;     // clear command: cursor back to the origin
  } cur_cmd_t;

  // Cursor state as seen by the sequencer.
  typedef struct packed {
    cell_t cursor;  // current position
    cell_t next;    // position after this beat's update
    logic  scroll;  // a write beat now would run past the last cell
  } cur_stat_t;

  // Result handed to the output register.
  typedef struct packed {
    logic  load;
    word_t word;
    logic  scrolled;
  } res_t;

endpackage

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// Linear cursor with a running column count, so that a newline needs no
// division to find the start of the next row.
// ----------------------------------------------------------------------------
module tcw_cursor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::cur_cmd_t  cmd_i,
  input  logic               newline_i,
  output tcw_pkg::cur_stat_t stat_o
);

  import tcw_pkg::*;

  cell_t             cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CELL_W:0]   next_lin;
  logic              scroll;
  logic              wrap_col;

  assign wrap_col = (col_q == COL_W'(COLUMNS - 1));

  always_comb begin
    if (newline_i) begin
      next_lin = {1'b0, cursor_q} + ((CELL_W + 1)'(COLUMNS) - (CELL_W + 1)'(col_q));
    end else begin
      next_lin = {1'b0, cursor_q} + (CELL_W + 1)'(1);
    end
    scroll = (next_lin >= (CELL_W + 1)'(CELL_COUNT));
  end

  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    if (cmd_i.home) begin
      cursor_d = '0;
      col_d    = '0;
    end else if (cmd_i.step) begin
      if (scroll) begin
        cursor_d = CELL_W'(LAST_ROW);
        col_d    = '0;
      end else begin
        cursor_d = next_lin[CELL_W-1:0];
        col_d    = (cmd_i.newline || wrap_col) ? '0 : col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
    end else begin
      cursor_q <= cursor_d;
      col_q    <= col_d;
    end
  end

  assign stat_o.cursor = cursor_q;
  assign stat_o.next   = cursor_d;
  assign stat_o.scroll = scroll;

endmodule

// ===== rtl/core/tcw_seq.sv =====
// ----------------------------------------------------------------------------
// tcw_seq
// Command sequencer: takes input beats, drives the screen RAM port and runs
// the clear, scroll and power-up clearing sweeps.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  tcw_pkg::char_t     char_code_i,
  input  tcw_pkg::cell_t     cell_index_i,
  input  tcw_pkg::attr_t     attr_i,
  input  logic               out_free_i,
  input  tcw_pkg::cur_stat_t cur_i,
  output tcw_pkg::cur_cmd_t  cur_cmd_o,
  output logic               newline_o,
  output logic               mem_we_o,
  output tcw_pkg::cell_t     mem_waddr_o,
  output tcw_pkg::word_t     mem_wdata_o,
  output logic               mem_re_o,
  output tcw_pkg::cell_t     mem_raddr_o,
  input  tcw_pkg::word_t     mem_rdata_i,
  output tcw_pkg::res_t      res_o
);

  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;

  logic [2:0] state_q, state_d;
  cell_t      idx_q, idx_d;
  cell_t      wr_addr_q, wr_addr_d;
  logic       wr_pend_q, wr_pend_d;
  word_t      blank_q, blank_d;
  logic       init_q, init_d;
  logic       in_range_q, in_range_d;
  logic       accept;
  logic       is_newline;
  logic       in_range;

  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_newline = (char_code_i == NEWLINE_CODE);
  assign in_range   = (cell_index_i < CELL_W'(CELL_COUNT));
  assign newline_o  = is_newline;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    wr_addr_d   = wr_addr_q;
    wr_pend_d   = 1'b0;
    blank_d     = blank_q;
    init_d      = init_q;
    in_range_d  = in_range_q;
    cur_cmd_o   = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_i.cursor;
    mem_wdata_o = {attr_i, char_code_i};
    mem_re_o    = 1'b0;
    mem_raddr_o = cell_index_i;
    res_o       = '0;

    // The copy read issued in the previous cycle lands here.
    if (wr_pend_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = wr_addr_q;
      mem_wdata_o = mem_rdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_WRITE: begin
              cur_cmd_o.step    = 1'b1;
              cur_cmd_o.newline = is_newline;
              mem_we_o          = !is_newline;
              if (cur_i.scroll) begin
                state_d = S_COPY;
                idx_d   = '0;
                blank_d = {attr_i, SPACE_CODE};
              end else begin
                res_o.load = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cur_cmd_o.home = 1'b1;
              state_d        = S_CLEAR;
              idx_d          = '0;
              blank_d        = {attr_i, SPACE_CODE};
            end
            CMD_READ: begin
              mem_re_o   = in_range;
              in_range_d = in_range;
              state_d    = S_READ;
            end
            default: begin
              res_o.load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_o.load = 1'b1;
        res_o.word = in_range_q ? mem_rdata_i : '0;
        state_d    = S_IDLE;
      end
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = blank_q;
        idx_d       = idx_q + CELL_W'(1);
        if (idx_q == CELL_W'(CELL_COUNT - 1)) begin
          state_d    = S_IDLE;
          init_d     = 1'b0;
          res_o.load = !init_q;
        end
      end
      S_COPY: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q + CELL_W'(COLUMNS);
        wr_pend_d   = 1'b1;
        wr_addr_d   = idx_q;
        idx_d       = idx_q + CELL_W'(1);
        if (idx_q == CELL_W'(LAST_ROW - 1)) begin
          state_d = S_FILL;
          idx_d   = CELL_W'(LAST_ROW);
        end
      end
      S_FILL: begin
        // The last copy write takes the port first, then the bottom row fills.
        if (!wr_pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q;
          mem_wdata_o = blank_q;
          idx_d       = idx_q + CELL_W'(1);
          if (idx_q == CELL_W'(CELL_COUNT - 1)) begin
            state_d        = S_IDLE;
            res_o.load     = 1'b1;
            res_o.scrolled = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      wr_pend_q <= 1'b0;
      blank_q   <= {ATTR_RESET, SPACE_CODE};
      init_q    <= 1'b1;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      wr_pend_q <= wr_pend_d;
      blank_q   <= blank_d;
      init_q    <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    in_range_q <= in_range_d;
  end

endmodule

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with an 80x25 screen RAM and a linear cursor.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen RAM to blanks, one cell a cycle, and
// holds in_ready_o low meanwhile; attribute writes are taken during the sweep.
// A character write, a newline or an unused command has its result beat
// offered in the cycle after it is taken. A read waits in S_READ for the
// registered RAM read data. A clear sweeps all 2000 cells. A write that runs
// past the last cell scrolls: 1920 cell copies through the RAM's single write
// port, one per cycle, then 80 blank writes for the bottom row. One beat is in
// work at a time, and a new beat is taken once the result register is free or
// being emptied.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  tcw_pkg::attr_t      cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  tcw_pkg::char_t      char_code_i,
  input  tcw_pkg::cell_t      cell_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcw_pkg::word_t      read_word_o,
  output tcw_pkg::cell_t      cursor_index_o,
  output logic                scrolled_o
);

  import tcw_pkg::*;

  attr_t     attr_q;
  logic      out_valid_q;
  word_t     read_word_q;
  cell_t     cursor_q;
  logic      scrolled_q;
  logic      out_free;
  cur_cmd_t  cur_cmd;
  cur_stat_t cur_stat;
  logic      newline;
  logic      mem_we;
  cell_t     mem_waddr;
  word_t     mem_wdata;
  logic      mem_re;
  cell_t     mem_raddr;
  word_t     mem_rdata;
  res_t      res;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_data_i;
    end
  end

  tcw_cursor u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cur_cmd),
    .newline_i (newline),
    .stat_o    (cur_stat)
  );

  tcw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr_q),
    .out_free_i   (out_free),
    .cur_i        (cur_stat),
    .cur_cmd_o    (cur_cmd),
    .newline_o    (newline),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .res_o        (res)
  );

  tcw_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result register; the cursor shown is the one after this beat's update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      read_word_q <= res.word;
      cursor_q    <= cur_stat.next;
      scrolled_q  <= res.scrolled;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_word_o    = read_word_q;
  assign cursor_index_o = cursor_q;
  assign scrolled_o     = scrolled_q;

endmodule

// ===== rtl/core/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to its top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tcw_pkg::word_t      read_word_o,
  input tcw_pkg::cell_t      cursor_index_o,
  input logic                scrolled_o
);

  import tcw_pkg::*;

  // A result beat that is not taken holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_word_o)
      && $stable(cursor_index_o) && $stable(scrolled_o))
    else $error("result beat changed while stalled");

  // The cursor never leaves the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cursor_index_o < CELL_W'(CELL_COUNT))
    else $error("cursor outside the screen");

  // A scroll always leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_index_o == CELL_W'(LAST_ROW))
    else $error("scroll left cursor off the bottom row start");

  // A scrolling beat returns no cell: its read word is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> read_word_o == '0)
    else $error("scrolling beat carries read data");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
